// File: hdl/rdc_pkg.sv
package rdc_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 22;

    // value register padded up to whole nibbles
    localparam int DIV_W     = ((VALUE_WIDTH + 3) / 4) * 4;
    localparam int NIBBLES   = DIV_W / 4;
    localparam int NIB_CNT_W = $clog2(NIBBLES);
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1);

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;

    localparam logic [1:0] OP_DEC  = 2'd0;
    localparam logic [1:0] OP_OCT  = 2'd1;
    localparam logic [1:0] OP_HEXL = 2'd2;
    localparam logic [1:0] OP_HEXU = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic       load;
        logic [1:0] op;
        logic       halt;
    } div_ctrl_t;

    typedef struct packed {
        logic       dig_valid;
        logic [3:0] digit;
        logic       final_dig;
    } div_stat_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             empty;
        logic [3:0]       top;
    } stk_stat_t;

    // one nibble step of a divide by ten: x = rem * 16 + nibble, x < 160
    function automatic logic [7:0] div10_step(input logic [7:0] x);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [7:0]  r;
        prod = 16'(x) * 16'd205;
        q    = prod[14:11];
        r    = x - 8'(q) * 8'd10;
        return {q, r[3:0]};
    endfunction

    function automatic logic [6:0] to_ascii(input logic [3:0] d, input logic upper);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = 7'd48 + 7'(d);
        end else if (upper) begin
            c = 7'd55 + 7'(d);
        end else begin
            c = 7'd87 + 7'(d);
        end
        return c;
    endfunction

endpackage

// File: hdl/radix_digit_converter_unit.sv
// channel   dir  ports                            word
// s_        in   s_tvalid s_tready s_tdata        value, opcode
// m_        out  m_tvalid m_tready m_tdata m_tlast digit char, last digit mark
//
// one word in, one digit word out per digit, most significant first
// decimal: one digit per pass of the nibble-serial divide by ten over the 64-bit value
// register; octal and hex: one digit per shift of three or four bits; then the stack drains
// s_tready is high only while idle; a finished digit may still wait in m_ meanwhile
// reset (aresetn low, synchronous) empties the digit stack and drops any word in flight
// m_tready low while m_tvalid is high holds the output register and pauses the drain
module radix_digit_converter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rdc_pkg::S_TDATA_W-1:0] s_tdata,  // value[63:0], opcode[65:64], zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rdc_pkg::M_TDATA_W-1:0] m_tdata,  // digit_char[6:0], zero pad
    output logic                          m_tlast   // last digit of the value
);

    rdc_pkg::state_t    state_reg, state_next;
    logic               upper_reg, upper_next;

    rdc_pkg::div_ctrl_t div_ctrl;
    rdc_pkg::div_stat_t div_stat;
    rdc_pkg::stk_stat_t stk_stat;

    logic               push;
    logic               pop;
    logic               stk_full_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [6:0]         char_reg, char_next;
    logic               last_reg, last_next;

    // the digit being pushed fills the last free slot
    assign stk_full_next = (stk_stat.count == rdc_pkg::CNT_W'(rdc_pkg::MAX_DIGITS - 1));

    rdc_divider u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (div_ctrl),
        .load_value (s_tdata[rdc_pkg::VALUE_WIDTH-1:0]),
        .stat       (div_stat)
    );

    rdc_digit_stack u_stk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_digit (div_stat.digit),
        .pop        (pop),
        .stat       (stk_stat)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rdc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = rdc_pkg::ST_CONVERT;
                end
            end
            rdc_pkg::ST_CONVERT: begin
                if (div_stat.dig_valid && (div_stat.final_dig || stk_full_next)) begin
                    state_next = rdc_pkg::ST_DRAIN;
                end
            end
            rdc_pkg::ST_DRAIN: begin
                if (pop && (stk_stat.count == rdc_pkg::CNT_W'(1))) begin
                    state_next = rdc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rdc_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_tready      = 1'b0;
        div_ctrl.load = 1'b0;
        div_ctrl.op   = s_tdata[65:64];
        div_ctrl.halt = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        case (state_reg)
            rdc_pkg::ST_IDLE: begin
                s_tready      = 1'b1;
                div_ctrl.load = s_tvalid;
            end
            rdc_pkg::ST_CONVERT: begin
                push          = div_stat.dig_valid;
                div_ctrl.halt = stk_full_next;
            end
            rdc_pkg::ST_DRAIN: begin
                pop = !stk_stat.empty && (!m_tvalid_reg || m_tready);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // hex case selection and output register
    always_comb begin
        upper_next    = upper_reg;
        m_tvalid_next = m_tvalid_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        if (div_ctrl.load) begin
            upper_next = (s_tdata[65:64] == rdc_pkg::OP_HEXU);
        end
        if (pop) begin
            m_tvalid_next = 1'b1;
            char_next     = rdc_pkg::to_ascii(stk_stat.top, upper_reg);
            last_next     = (stk_stat.count == rdc_pkg::CNT_W'(1));
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rdc_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        upper_reg <= upper_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

endmodule

// File: hdl/rdc_divider.sv
module rdc_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rdc_pkg::div_ctrl_t              ctrl,
    input  logic [rdc_pkg::VALUE_WIDTH-1:0] load_value,
    output rdc_pkg::div_stat_t              stat
);

    logic [rdc_pkg::DIV_W-1:0]     val_reg, val_next;
    logic [3:0]                    rem_reg, rem_next;
    logic [rdc_pkg::NIB_CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]                    op_reg, op_next;
    logic                          busy_reg, busy_next;

    logic [7:0]                    step_qr;
    logic [rdc_pkg::DIV_W-1:0]     quot;
    logic                          last_nib;

    assign step_qr  = rdc_pkg::div10_step({rem_reg, val_reg[rdc_pkg::DIV_W-1 -: 4]});
    assign last_nib = (cnt_reg == rdc_pkg::NIB_CNT_W'(rdc_pkg::NIBBLES - 1));

    always_comb begin
        quot           = val_reg;
        stat.dig_valid = 1'b0;
        stat.digit     = 4'd0;
        case (op_reg)
            rdc_pkg::OP_DEC: begin
                // one nibble per cycle, quotient shifts in at the bottom
                quot           = {val_reg[rdc_pkg::DIV_W-5:0], step_qr[7:4]};
                stat.dig_valid = busy_reg & last_nib;
                stat.digit     = step_qr[3:0];
            end
            rdc_pkg::OP_OCT: begin
                quot           = val_reg >> 3;
                stat.dig_valid = busy_reg;
                stat.digit     = {1'b0, val_reg[2:0]};
            end
            default: begin
                quot           = val_reg >> 4;
                stat.dig_valid = busy_reg;
                stat.digit     = val_reg[3:0];
            end
        endcase
        stat.final_dig = (quot == '0);
    end

    always_comb begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        if (ctrl.load) begin
            val_next  = rdc_pkg::DIV_W'(load_value);
            rem_next  = 4'd0;
            cnt_next  = '0;
            op_next   = ctrl.op;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            val_next = quot;
            if (op_reg == rdc_pkg::OP_DEC) begin
                if (last_nib) begin
                    rem_next = 4'd0;
                    cnt_next = '0;
                end else begin
                    rem_next = step_qr[3:0];
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            if (stat.dig_valid && (stat.final_dig || ctrl.halt)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        op_reg  <= op_next;
    end

endmodule

// File: hdl/rdc_digit_stack.sv
module rdc_digit_stack (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [3:0]         push_digit,
    input  logic               pop,
    output rdc_pkg::stk_stat_t stat
);

    logic [3:0]               ent_reg  [rdc_pkg::MAX_DIGITS];
    logic [3:0]               ent_next [rdc_pkg::MAX_DIGITS];
    logic [rdc_pkg::CNT_W-1:0] count_reg, count_next;

    // lifo as a shift line: push shifts up, pop shifts down
    always_comb begin
        for (int i = 0; i < rdc_pkg::MAX_DIGITS; i++) begin
            ent_next[i] = ent_reg[i];
        end
        count_next = count_reg;
        if (push) begin
            ent_next[0] = push_digit;
            for (int i = 1; i < rdc_pkg::MAX_DIGITS; i++) begin
                ent_next[i] = ent_reg[i-1];
            end
            count_next = count_reg + 1'b1;
        end else if (pop) begin
            for (int i = 0; i < rdc_pkg::MAX_DIGITS - 1; i++) begin
                ent_next[i] = ent_reg[i+1];
            end
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < rdc_pkg::MAX_DIGITS; i++) begin
            ent_reg[i] <= ent_next[i];
        end
    end

    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.top   = ent_reg[0];

endmodule
